>>> src/cau_pkg.sv
// Shared types, constants and command codes for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 64;
    localparam int DIV_STEPS     = 33;
    localparam int DIV_LAT       = DIV_STEPS + 1;
    localparam int SQRT_STEPS    = 32;
    localparam int SQRT_PAD      = DIV_LAT - SQRT_STEPS;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_CONJ = 3'd4;
    localparam logic [2:0] CMD_MOD  = 3'd5;
    localparam logic [2:0] CMD_EQ   = 3'd6;

    localparam logic [DATA_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } t_clip;

    // Per-item data that rides alongside the divider and root pipelines
    typedef struct packed {
        logic [2:0]        cmd;
        logic [DATA_W-1:0] res_re;
        logic [DATA_W-1:0] res_im;
        logic              eq;
        logic              sat;
        logic              dz;
        logic              neg_re;
        logic              neg_im;
    } t_side;

    typedef struct packed {
        logic [DATA_W-1:0] res_re;
        logic [DATA_W-1:0] res_im;
        logic              eq;
        logic              dz;
        logic              sat;
    } t_res;

endpackage

`default_nettype wire

>>> src/cau_front.sv
// Front stages: products, sums, rounding and the simple operations.
`default_nettype none

module cau_front import cau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic [2:0]               i_command,
    input  wire logic signed [DATA_W-1:0] i_a_real,
    input  wire logic signed [DATA_W-1:0] i_a_imag,
    input  wire logic signed [DATA_W-1:0] i_b_real,
    input  wire logic signed [DATA_W-1:0] i_b_imag,
    output logic                          o_valid,
    output t_side                         o_side,
    output logic [PROD_W-1:0]             o_mag_re,
    output logic [PROD_W-1:0]             o_mag_im,
    output logic [PROD_W-1:0]             o_sq
);

    localparam logic signed [PROD_W:0] HALF  = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W:0] W_MAX = 65'sd2147483647;
    localparam logic signed [PROD_W:0] W_MIN = -65'sd2147483648;
    localparam logic signed [DATA_W:0] N_MAX = 33'sd2147483647;
    localparam logic signed [DATA_W:0] N_MIN = -33'sd2147483648;

    function automatic t_clip clip_wide(input logic signed [PROD_W:0] v);
        t_clip c;
        c.sat = 1'b0;
        c.val = v[DATA_W-1:0];
        if (v > W_MAX) begin
            c.sat = 1'b1;
            c.val = POS_LIMIT;
        end else if (v < W_MIN) begin
            c.sat = 1'b1;
            c.val = NEG_LIMIT;
        end
        return c;
    endfunction

    function automatic t_clip clip_narrow(input logic signed [DATA_W:0] v);
        t_clip c;
        c.sat = 1'b0;
        c.val = v[DATA_W-1:0];
        if (v > N_MAX) begin
            c.sat = 1'b1;
            c.val = POS_LIMIT;
        end else if (v < N_MIN) begin
            c.sat = 1'b1;
            c.val = NEG_LIMIT;
        end
        return c;
    endfunction

    // stage 1: products
    logic                     r_v1, r_v2, r_v3;
    logic [2:0]               r_cmd1;
    logic signed [DATA_W-1:0] r_ar1, r_ai1, r_br1, r_bi1;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [DATA_W-1:0] w_sq_a, w_sq_b;
    logic signed [PROD_W-1:0] n_p0, n_p1, n_p2, n_p3, n_p4, n_p5;

    // stage 2: sums and simple results
    logic signed [PROD_W:0]   r_nre, r_nim, n_nre, n_nim;
    logic [PROD_W-1:0]        r_sq2, n_sq2;
    t_side                    r_side2, n_side2;
    logic signed [DATA_W:0]   w_sum_re, w_sum_im, w_neg_ai;
    t_clip                    w_c_re, w_c_im, w_c_conj;

    // stage 3: rounding and magnitudes
    t_side                    r_side3, n_side3;
    logic [PROD_W-1:0]        r_mag_re, r_mag_im, r_sq3;
    logic [PROD_W-1:0]        n_mag_re, n_mag_im;
    logic signed [PROD_W:0]   w_rnd_re, w_rnd_im;
    t_clip                    w_m_re, w_m_im;

    always_comb begin
        w_sq_a = (i_command == CMD_MOD) ? i_a_real : i_b_real;
        w_sq_b = (i_command == CMD_MOD) ? i_a_imag : i_b_imag;
        n_p0   = i_a_real * i_b_real;
        n_p1   = i_a_imag * i_b_imag;
        n_p2   = i_a_real * i_b_imag;
        n_p3   = i_a_imag * i_b_real;
        n_p4   = w_sq_a * w_sq_a;
        n_p5   = w_sq_b * w_sq_b;
    end

    always_comb begin
        if (r_cmd1 == CMD_MUL) begin
            n_nre = 65'(r_p0) - 65'(r_p1);
            n_nim = 65'(r_p2) + 65'(r_p3);
        end else begin
            n_nre = 65'(r_p0) + 65'(r_p1);
            n_nim = 65'(r_p3) - 65'(r_p2);
        end
        n_sq2 = r_p4[PROD_W-1:0] + r_p5[PROD_W-1:0];

        if (r_cmd1 == CMD_SUB) begin
            w_sum_re = 33'(r_ar1) - 33'(r_br1);
            w_sum_im = 33'(r_ai1) - 33'(r_bi1);
        end else begin
            w_sum_re = 33'(r_ar1) + 33'(r_br1);
            w_sum_im = 33'(r_ai1) + 33'(r_bi1);
        end
        w_neg_ai = -33'(r_ai1);
        w_c_re   = clip_narrow(w_sum_re);
        w_c_im   = clip_narrow(w_sum_im);
        w_c_conj = clip_narrow(w_neg_ai);

        n_side2     = '0;
        n_side2.cmd = r_cmd1;
        unique case (r_cmd1)
            CMD_ADD, CMD_SUB: begin
                n_side2.res_re = w_c_re.val;
                n_side2.res_im = w_c_im.val;
                n_side2.sat    = w_c_re.sat | w_c_im.sat;
            end
            CMD_CONJ: begin
                n_side2.res_re = r_ar1;
                n_side2.res_im = w_c_conj.val;
                n_side2.sat    = w_c_conj.sat;
            end
            CMD_EQ: begin
                n_side2.eq = (r_ar1 == r_br1) && (r_ai1 == r_bi1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        // round half away from zero: add half, less one when negative
        w_rnd_re = r_nre + HALF - $signed({64'd0, r_nre[PROD_W]});
        w_rnd_im = r_nim + HALF - $signed({64'd0, r_nim[PROD_W]});
        w_m_re   = clip_wide(w_rnd_re >>> FRAC_BITS);
        w_m_im   = clip_wide(w_rnd_im >>> FRAC_BITS);
        n_mag_re = r_nre[PROD_W] ? 64'(-r_nre) : r_nre[PROD_W-1:0];
        n_mag_im = r_nim[PROD_W] ? 64'(-r_nim) : r_nim[PROD_W-1:0];

        n_side3        = r_side2;
        n_side3.neg_re = r_nre[PROD_W];
        n_side3.neg_im = r_nim[PROD_W];
        n_side3.dz     = (r_side2.cmd == CMD_DIV) && (r_sq2 == '0);
        if (r_side2.cmd == CMD_MUL) begin
            n_side3.res_re = w_m_re.val;
            n_side3.res_im = w_m_im.val;
            n_side3.sat    = w_m_re.sat | w_m_im.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd1   <= i_command;
            r_ar1    <= i_a_real;
            r_ai1    <= i_a_imag;
            r_br1    <= i_b_real;
            r_bi1    <= i_b_imag;
            r_p0     <= n_p0;
            r_p1     <= n_p1;
            r_p2     <= n_p2;
            r_p3     <= n_p3;
            r_p4     <= n_p4;
            r_p5     <= n_p5;
            r_nre    <= n_nre;
            r_nim    <= n_nim;
            r_sq2    <= n_sq2;
            r_side2  <= n_side2;
            r_side3  <= n_side3;
            r_mag_re <= n_mag_re;
            r_mag_im <= n_mag_im;
            r_sq3    <= r_sq2;
        end
    end

    assign o_valid  = r_v3;
    assign o_side   = r_side3;
    assign o_mag_re = r_mag_re;
    assign o_mag_im = r_mag_im;
    assign o_sq     = r_sq3;

endmodule

`default_nettype wire

>>> src/cau_div.sv
// Pipelined restoring divider lane: one quotient bit per stage.
`default_nettype none

module cau_div import cau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [PROD_W-1:0]    i_mag,
    input  wire logic [PROD_W-1:0]    i_den,
    output logic [DIV_STEPS-1:0]      o_quot,
    output logic                      o_ovf
);

    logic [PROD_W-1:0]    r_rem [0:DIV_STEPS-1];
    logic [PROD_W-1:0]    r_den [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] r_dvd [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] r_q   [0:DIV_STEPS];
    logic                 r_ovf [0:DIV_STEPS];
    logic [PROD_W-1:0]    w_top;

    // quotient below 2^DIV_STEPS only when the upper dividend part is below the divisor
    assign w_top = i_mag >> (DIV_STEPS - FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_top;
            r_den[0] <= i_den;
            r_dvd[0] <= {i_mag[DIV_STEPS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            r_q[0]   <= '0;
            r_ovf[0] <= (w_top >= i_den);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [PROD_W:0]   w_trial;
        logic              w_ge;
        logic [PROD_W-1:0] w_next;

        assign w_trial = {r_rem[k], r_dvd[k][DIV_STEPS-1]};
        assign w_ge    = (w_trial >= {1'b0, r_den[k]});
        assign w_next  = w_ge ? 64'(w_trial - {1'b0, r_den[k]}) : w_trial[PROD_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1]   <= {r_q[k][DIV_STEPS-2:0], w_ge};
                r_ovf[k+1] <= r_ovf[k];
            end
        end

        if (k < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_next;
                    r_den[k+1] <= r_den[k];
                    r_dvd[k+1] <= r_dvd[k] << 1;
                end
            end
        end
    end

    assign o_quot = r_q[DIV_STEPS];
    assign o_ovf  = r_ovf[DIV_STEPS];

endmodule

`default_nettype wire

>>> src/cau_sqrt.sv
// Pipelined integer square root: one root bit per stage, then delay to match the divider.
`default_nettype none

module cau_sqrt import cau_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [PROD_W-1:0] i_x,
    output logic [DATA_W-1:0]      o_root
);

    logic [PROD_W-1:0] r_x   [1:SQRT_STEPS-1];
    logic [PROD_W-1:0] r_res [1:SQRT_STEPS];
    logic [DATA_W-1:0] r_pad [0:SQRT_PAD-1];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [PROD_W-1:0] BIT = 64'd1 << (PROD_W - 2 - 2 * k);
        logic [PROD_W-1:0] w_xin, w_rin;
        logic [PROD_W:0]   w_sum;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_xin = i_x;
            assign w_rin = '0;
        end else begin : g_mid
            assign w_xin = r_x[k];
            assign w_rin = r_res[k];
        end

        assign w_sum = {1'b0, w_rin} + {1'b0, BIT};
        assign w_ge  = ({1'b0, w_xin} >= w_sum);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[k+1] <= w_ge ? (w_rin >> 1) + BIT : (w_rin >> 1);
            end
        end

        if (k < SQRT_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k+1] <= w_ge ? w_xin - w_sum[PROD_W-1:0] : w_xin;
                end
            end
        end
    end

    for (genvar p = 0; p < SQRT_PAD; p++) begin : g_pad
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (p == 0) begin
                    r_pad[p] <= r_res[SQRT_STEPS][DATA_W-1:0];
                end else begin
                    r_pad[p] <= r_pad[(p == 0) ? 0 : p - 1];
                end
            end
        end
    end

    assign o_root = r_pad[SQRT_PAD-1];

endmodule

`default_nettype wire

>>> src/cau_obuf.sv
// Two-entry output buffer that decouples the pipeline from the receiver.
`default_nettype none

module cau_obuf import cau_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_res i_data,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_data
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0] r_cnt, n_cnt;
    t_res       r_e0, r_e1;
    logic       w_pop;

    assign w_pop = (r_cnt != CNT_EMPTY) && i_ready;
    assign n_cnt = r_cnt + 2'(i_push) - 2'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_EMPTY;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == CNT_FULL) begin
                r_e0 <= r_e1;
                if (i_push) begin
                    r_e1 <= i_data;
                end
            end else if (i_push) begin
                r_e0 <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == CNT_ONE) begin
                r_e1 <= i_data;
            end else begin
                r_e0 <= i_data;
            end
        end
    end

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != CNT_EMPTY);
    assign o_data  = r_e0;

endmodule

`default_nettype wire

>>> src/complex_arithmetic_unit.sv
// Complex-number ALU on signed fixed point operands, fully pipelined.
//
// Input channel i_valid/o_ready carries one beat per operation: a command and
// operands A and B. Output channel o_valid/i_ready returns exactly one result
// beat per input beat, in order.
// From input beat to output valid the path runs through three front stages
// (products, sums, rounding), 34 stages of divider and root work, and the
// output buffer register. Every operation takes the same path length.
// Throughput is one beat per cycle; the divider lanes retire one quotient bit
// and the root unit one root bit per stage, so no operation repeats a stage.
// The pipeline advances while the two-entry output buffer is not full, so a
// new beat is still taken while one result waits for the receiver. When the
// receiver stalls long enough to fill the buffer, o_ready drops and the whole
// pipeline holds; nothing is dropped or repeated.
// Reset clears all valid bits and empties the output buffer; o_ready is high
// in the first cycle after reset.
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [2:0]               i_command,
    input  wire logic signed [DATA_W-1:0] i_a_real,
    input  wire logic signed [DATA_W-1:0] i_a_imag,
    input  wire logic signed [DATA_W-1:0] i_b_real,
    input  wire logic signed [DATA_W-1:0] i_b_imag,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [DATA_W-1:0]      o_res_real,
    output logic signed [DATA_W-1:0]      o_res_imag,
    output logic                          o_is_equal,
    output logic                          o_divide_by_zero,
    output logic                          o_saturated
);

    function automatic t_clip clip_div(input logic neg, input logic [DIV_STEPS-1:0] q,
                                       input logic ovf);
        t_clip c;
        c.sat = 1'b0;
        if (!neg) begin
            c.val = q[DATA_W-1:0];
            if (ovf || (q > {1'b0, POS_LIMIT})) begin
                c.sat = 1'b1;
                c.val = POS_LIMIT;
            end
        end else begin
            c.val = 32'(33'd0 - q);
            if (ovf || (q > {1'b0, NEG_LIMIT})) begin
                c.sat = 1'b1;
                c.val = NEG_LIMIT;
            end
        end
        return c;
    endfunction

    logic                 w_en, w_full, w_push;
    logic                 w_f_valid;
    t_side                w_f_side;
    logic [PROD_W-1:0]    w_mag_re, w_mag_im, w_sq;
    logic [DIV_STEPS-1:0] w_q_re, w_q_im;
    logic                 w_ovf_re, w_ovf_im;
    logic [DATA_W-1:0]    w_root;
    t_side                r_side [0:DIV_LAT-1];
    logic                 r_v    [0:DIV_LAT-1];
    t_side                w_s;
    t_clip                w_d_re, w_d_im;
    t_res                 n_res, w_out;

    assign w_en    = !w_full;
    assign o_ready = w_en;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_a_real  (i_a_real),
        .i_a_imag  (i_a_imag),
        .i_b_real  (i_b_real),
        .i_b_imag  (i_b_imag),
        .o_valid   (w_f_valid),
        .o_side    (w_f_side),
        .o_mag_re  (w_mag_re),
        .o_mag_im  (w_mag_im),
        .o_sq      (w_sq)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mag  (w_mag_re),
        .i_den  (w_sq),
        .o_quot (w_q_re),
        .o_ovf  (w_ovf_re)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mag  (w_mag_im),
        .i_den  (w_sq),
        .o_quot (w_q_im),
        .o_ovf  (w_ovf_im)
    );

    cau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (w_sq),
        .o_root (w_root)
    );

    // side data and valid bits advance in step with the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_v[0] <= w_f_valid;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_f_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    always_comb begin
        w_s    = r_side[DIV_LAT-1];
        w_d_re = clip_div(w_s.neg_re, w_q_re, w_ovf_re);
        w_d_im = clip_div(w_s.neg_im, w_q_im, w_ovf_im);

        n_res.res_re = w_s.res_re;
        n_res.res_im = w_s.res_im;
        n_res.eq     = w_s.eq;
        n_res.dz     = 1'b0;
        n_res.sat    = w_s.sat;
        unique case (w_s.cmd)
            CMD_DIV: begin
                if (w_s.dz) begin
                    n_res.res_re = '0;
                    n_res.res_im = '0;
                    n_res.dz     = 1'b1;
                    n_res.sat    = 1'b0;
                end else begin
                    n_res.res_re = w_d_re.val;
                    n_res.res_im = w_d_im.val;
                    n_res.sat    = w_d_re.sat | w_d_im.sat;
                end
            end
            CMD_MOD: begin
                n_res.res_im = '0;
                if (w_root > POS_LIMIT) begin
                    n_res.res_re = POS_LIMIT;
                    n_res.sat    = 1'b1;
                end else begin
                    n_res.res_re = w_root;
                    n_res.sat    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_push = w_en && r_v[DIV_LAT-1];

    cau_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (n_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out)
    );

    assign o_res_real       = w_out.res_re;
    assign o_res_imag       = w_out.res_im;
    assign o_is_equal       = w_out.eq;
    assign o_divide_by_zero = w_out.dz;
    assign o_saturated      = w_out.sat;

`ifndef NO_ASSERTIONS
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result waiting");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_equal && o_divide_by_zero))
        else $error("equal and divide-by-zero flags both set");

    a_dz_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |->
            (o_res_real == '0 && o_res_imag == '0 && !o_saturated))
        else $error("divide by zero gave a nonzero result");

    a_eq_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_equal) |->
            (o_res_real == '0 && o_res_imag == '0 && !o_saturated))
        else $error("equal compare gave a nonzero result");
`endif

endmodule

`default_nettype wire
